// ===== rtl/mhpq_pkg.sv =====
package mhpq_pkg;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_PUSHED       = 2'd0,
    STAT_POPPED       = 2'd1,
    STAT_REFUSE_FULL  = 2'd2,
    STAT_REFUSE_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_DN_LOAD,
    ST_DN_RD,
    ST_DN_CMPL,
    ST_DN_CMPR
  } state_e;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pri;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] task_id;
    logic [15:0] priority_req;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_id;
    logic [15:0] out_priority;
    logic [7:0]  count;
  } out_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== rtl/mhpq_heap_ram.sv =====
module mhpq_heap_ram #(
  parameter int CAPACITY = 128,
  parameter int IW       = 7
) (
  input  logic              clk_i,
  input  mhpq_pkg::mem_ctl_t ctl_i,
  input  logic [IW-1:0]     waddr_i,
  input  mhpq_pkg::entry_t  wdata_i,
  input  logic [IW-1:0]     raddr0_i,
  input  logic [IW-1:0]     raddr1_i,
  output mhpq_pkg::entry_t  rdata0_o,
  output mhpq_pkg::entry_t  rdata1_o
);

  mhpq_pkg::entry_t mem [CAPACITY];
  mhpq_pkg::entry_t rdata0_q;
  mhpq_pkg::entry_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata0_q <= mem[raddr0_i];
      rdata1_q <= mem[raddr1_i];
    end
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

// ===== rtl/mhpq_cmp.sv =====
module mhpq_cmp (
  input  mhpq_pkg::entry_t a_i,
  input  mhpq_pkg::entry_t b_i,
  output logic             a_first_o
);

  always_comb begin
    if (a_i.pri != b_i.pri) begin
      a_first_o = a_i.pri < b_i.pri;
    end else begin
      a_first_o = a_i.stamp < b_i.stamp;
    end
  end

endmodule

// ===== rtl/mhpq_ctrl.sv =====
module mhpq_ctrl #(
  parameter int CAPACITY = 128,
  parameter int IW       = 7,
  parameter int OW       = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mhpq_pkg::in_t      req_i,
  output logic               done_o,
  output mhpq_pkg::out_t     rsp_o,
  output mhpq_pkg::mem_ctl_t mem_ctl_o,
  output logic [IW-1:0]      waddr_o,
  output mhpq_pkg::entry_t   wdata_o,
  output logic [IW-1:0]      raddr0_o,
  output logic [IW-1:0]      raddr1_o,
  input  mhpq_pkg::entry_t   rdata0_i,
  input  mhpq_pkg::entry_t   rdata1_i,
  output mhpq_pkg::entry_t   cmp_a_o,
  output mhpq_pkg::entry_t   cmp_b_o,
  input  logic               cmp_first_i
);

  localparam int CW = IW + 2;

  mhpq_pkg::state_e state_q, state_d;
  logic [IW-1:0]    idx_q, idx_d;
  logic [OW-1:0]    occ_q, occ_d;
  logic [31:0]      stamp_q, stamp_d;
  mhpq_pkg::entry_t x_q, x_d;
  mhpq_pkg::entry_t best_q, best_d;
  logic             took_left_q, took_left_d;
  mhpq_pkg::out_t   rsp_q, rsp_d;
  logic             done_q, done_d;

  logic [IW-1:0] parent;
  logic [CW-1:0] left_w, right_w, occ_w;
  logic          left_ok, right_ok;
  logic          full, empty;

  assign parent   = IW'((idx_q - 1'b1) >> 1);
  assign left_w   = CW'({idx_q, 1'b1});
  assign right_w  = left_w + 1'b1;
  assign occ_w    = CW'(occ_q);
  assign left_ok  = left_w < occ_w;
  assign right_ok = right_w < occ_w;
  assign full     = occ_q == OW'(CAPACITY);
  assign empty    = occ_q == '0;

  assign cmp_a_o = (state_q == mhpq_pkg::ST_DN_CMPR) ? rdata1_i : rdata0_i;
  assign cmp_b_o = (state_q == mhpq_pkg::ST_DN_CMPR) ? best_q : x_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mhpq_pkg::ST_IDLE: begin
        if (start) begin
          if (req_i.kind == mhpq_pkg::KIND_PUSH) begin
            if (!full) state_d = mhpq_pkg::ST_UP_CHK;
          end else if (!empty) begin
            state_d = mhpq_pkg::ST_DN_LOAD;
          end
        end
      end
      mhpq_pkg::ST_UP_CHK: begin
        state_d = (idx_q == '0) ? mhpq_pkg::ST_IDLE : mhpq_pkg::ST_UP_CMP;
      end
      mhpq_pkg::ST_UP_CMP: begin
        state_d = cmp_first_i ? mhpq_pkg::ST_IDLE : mhpq_pkg::ST_UP_CHK;
      end
      mhpq_pkg::ST_DN_LOAD: begin
        state_d = empty ? mhpq_pkg::ST_IDLE : mhpq_pkg::ST_DN_RD;
      end
      mhpq_pkg::ST_DN_RD: begin
        state_d = left_ok ? mhpq_pkg::ST_DN_CMPL : mhpq_pkg::ST_IDLE;
      end
      mhpq_pkg::ST_DN_CMPL: begin
        state_d = mhpq_pkg::ST_DN_CMPR;
      end
      mhpq_pkg::ST_DN_CMPR: begin
        if ((right_ok && cmp_first_i) || took_left_q) begin
          state_d = mhpq_pkg::ST_DN_RD;
        end else begin
          state_d = mhpq_pkg::ST_IDLE;
        end
      end
      default: state_d = mhpq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_d       = idx_q;
    occ_d       = occ_q;
    stamp_d     = stamp_q;
    x_d         = x_q;
    best_d      = best_q;
    took_left_d = took_left_q;
    rsp_d       = rsp_q;
    done_d      = 1'b0;
    mem_ctl_o   = '0;
    waddr_o     = idx_q;
    wdata_o     = x_q;
    raddr0_o    = '0;
    raddr1_o    = '0;
    busy        = state_q != mhpq_pkg::ST_IDLE;

    unique case (state_q)
      mhpq_pkg::ST_IDLE: begin
        if (start) begin
          rsp_d.out_id       = '0;
          rsp_d.out_priority = '0;
          rsp_d.count        = 8'(occ_q);
          if (req_i.kind == mhpq_pkg::KIND_PUSH) begin
            if (full) begin
              rsp_d.status = mhpq_pkg::STAT_REFUSE_FULL;
              done_d       = 1'b1;
            end else begin
              x_d.id    = req_i.task_id;
              x_d.pri   = req_i.priority_req;
              x_d.stamp = stamp_q;
              stamp_d   = stamp_q + 32'd1;
              idx_d     = IW'(occ_q);
              occ_d     = occ_q + 1'b1;
            end
          end else if (empty) begin
            rsp_d.status = mhpq_pkg::STAT_REFUSE_EMPTY;
            done_d       = 1'b1;
          end else begin
            mem_ctl_o.re = 1'b1;
            raddr0_o     = '0;
            raddr1_o     = IW'(occ_q - 1'b1);
            occ_d        = occ_q - 1'b1;
          end
        end
      end
      mhpq_pkg::ST_UP_CHK: begin
        if (idx_q == '0) begin
          mem_ctl_o.we = 1'b1;
          rsp_d.status = mhpq_pkg::STAT_PUSHED;
          rsp_d.count  = 8'(occ_q);
          done_d       = 1'b1;
        end else begin
          mem_ctl_o.re = 1'b1;
          raddr0_o     = parent;
        end
      end
      mhpq_pkg::ST_UP_CMP: begin
        mem_ctl_o.we = 1'b1;
        if (cmp_first_i) begin
          rsp_d.status = mhpq_pkg::STAT_PUSHED;
          rsp_d.count  = 8'(occ_q);
          done_d       = 1'b1;
        end else begin
          wdata_o = rdata0_i;
          idx_d   = parent;
        end
      end
      mhpq_pkg::ST_DN_LOAD: begin
        rsp_d.out_id       = rdata0_i.id;
        rsp_d.out_priority = rdata0_i.pri;
        rsp_d.status       = mhpq_pkg::STAT_POPPED;
        rsp_d.count        = 8'(occ_q);
        x_d                = rdata1_i;
        idx_d              = '0;
        done_d             = empty;
      end
      mhpq_pkg::ST_DN_RD: begin
        if (left_ok) begin
          mem_ctl_o.re = 1'b1;
          raddr0_o     = IW'(left_w);
          raddr1_o     = IW'(right_w);
        end else begin
          mem_ctl_o.we = 1'b1;
          done_d       = 1'b1;
        end
      end
      mhpq_pkg::ST_DN_CMPL: begin
        took_left_d = cmp_first_i;
        best_d      = cmp_first_i ? rdata0_i : x_q;
      end
      mhpq_pkg::ST_DN_CMPR: begin
        mem_ctl_o.we = 1'b1;
        if (right_ok && cmp_first_i) begin
          wdata_o = rdata1_i;
          idx_d   = IW'(right_w);
        end else if (took_left_q) begin
          wdata_o = best_q;
          idx_d   = IW'(left_w);
        end else begin
          done_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mhpq_pkg::ST_IDLE;
      occ_q       <= '0;
      stamp_q     <= '0;
      done_q      <= 1'b0;
      idx_q       <= '0;
      took_left_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      stamp_q     <= stamp_d;
      done_q      <= done_d;
      idx_q       <= idx_d;
      took_left_q <= took_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    best_q <= best_d;
    rsp_q  <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// ===== rtl/min_heap_priority_queue_top.sv =====
// Push: the new entry climbs from the last slot toward the root and stops at the root
//   or when its parent goes first. Refused items answer in the cycle after start.
// Pop: the last entry moves to the root and sinks until it reaches a leaf or neither child
//   goes first; a pop that leaves the heap empty skips the sink.
// One item at a time: busy drops in the cycle of the result beat; results cannot stall.
// Reset clears occupancy and the arrival stamp; heap RAM contents are not cleared.
module min_heap_priority_queue_top #(
  parameter int CAPACITY = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  mhpq_pkg::in_t  req_i,
  output logic           done_o,
  output mhpq_pkg::out_t rsp_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);

  mhpq_pkg::mem_ctl_t mem_ctl;
  logic [IW-1:0]      waddr, raddr0, raddr1;
  mhpq_pkg::entry_t   wdata, rdata0, rdata1;
  mhpq_pkg::entry_t   cmp_a, cmp_b;
  logic               cmp_first;

  mhpq_ctrl #(
    .CAPACITY (CAPACITY),
    .IW       (IW),
    .OW       (OW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .mem_ctl_o   (mem_ctl),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr0_o    (raddr0),
    .raddr1_o    (raddr1),
    .rdata0_i    (rdata0),
    .rdata1_i    (rdata1),
    .cmp_a_o     (cmp_a),
    .cmp_b_o     (cmp_b),
    .cmp_first_i (cmp_first)
  );

  mhpq_heap_ram #(
    .CAPACITY (CAPACITY),
    .IW       (IW)
  ) u_ram (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  mhpq_cmp u_cmp (
    .a_i       (cmp_a),
    .b_i       (cmp_b),
    .a_first_o (cmp_first)
  );

endmodule

// ===== sim/min_heap_priority_queue_top_tb.sv =====
`timescale 1ns / 1ps

module min_heap_priority_queue_top_tb;

  localparam int CAP          = 128;
  localparam int TAIL_CYCLES  = 60;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  logic           done_o;
  mhpq_pkg::in_t  req_i;
  mhpq_pkg::out_t rsp_o;
  bit             quiet;

  class pq_scoreboard;
    mhpq_pkg::entry_t heap[CAP];
    int unsigned      occ;
    logic [31:0]      next_stamp;
    mhpq_pkg::out_t   pending_rsp[$];
    int unsigned      errors;

    function new();
      occ        = 0;
      next_stamp = '0;
      errors     = 0;
    endfunction

    function bit precedes(mhpq_pkg::entry_t a, mhpq_pkg::entry_t b);
      if (a.pri != b.pri) return a.pri < b.pri;
      return a.stamp < b.stamp;
    endfunction

    function void swap_entries(int unsigned i, int unsigned j);
      mhpq_pkg::entry_t t;
      t       = heap[i];
      heap[i] = heap[j];
      heap[j] = t;
    endfunction

    function mhpq_pkg::out_t predict_response(mhpq_pkg::in_t it);
      mhpq_pkg::out_t   r;
      mhpq_pkg::entry_t fresh;
      int unsigned      idx;
      int unsigned      parent;
      int unsigned      left;
      int unsigned      right;
      int unsigned      best;
      r = '0;
      if (it.kind == mhpq_pkg::KIND_PUSH) begin
        if (occ >= CAP) begin
          r.status = mhpq_pkg::STAT_REFUSE_FULL;
        end else begin
          fresh.id    = it.task_id;
          fresh.pri   = it.priority_req;
          fresh.stamp = next_stamp;
          idx         = occ;
          heap[idx]   = fresh;
          next_stamp  = next_stamp + 32'd1;
          occ         = occ + 1;
          while (idx > 0) begin
            parent = (idx - 1) / 2;
            if (precedes(heap[parent], heap[idx])) break;
            swap_entries(parent, idx);
            idx = parent;
          end
          r.status = mhpq_pkg::STAT_PUSHED;
        end
      end else if (occ == 0) begin
        r.status = mhpq_pkg::STAT_REFUSE_EMPTY;
      end else begin
        r.out_id       = heap[0].id;
        r.out_priority = heap[0].pri;
        heap[0]        = heap[occ - 1];
        occ            = occ - 1;
        idx            = 0;
        while (1) begin
          left  = idx * 2 + 1;
          right = idx * 2 + 2;
          best  = idx;
          if (left < occ && precedes(heap[left], heap[best])) best = left;
          if (right < occ && precedes(heap[right], heap[best])) best = right;
          if (best == idx) break;
          swap_entries(idx, best);
          idx = best;
        end
        r.status = mhpq_pkg::STAT_POPPED;
      end
      r.count = 8'(occ);
      return r;
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void note_request(mhpq_pkg::in_t it);
      pending_rsp.push_back(predict_response(it));
    endfunction

    task check_response(mhpq_pkg::out_t got);
      mhpq_pkg::out_t want;
      if (pending_rsp.size() == 0) begin
        report_mismatch($sformatf("unexpected beat status=%0d id=%h pri=%h count=%0d",
                                  got.status, got.out_id, got.out_priority, got.count));
        return;
      end
      want = pending_rsp.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.out_id !== want.out_id)
        report_mismatch($sformatf("out_id %h, want %h", got.out_id, want.out_id));
      if (got.out_priority !== want.out_priority)
        report_mismatch($sformatf("out_priority %h, want %h",
                                  got.out_priority, want.out_priority));
      if (got.count !== want.count)
        report_mismatch($sformatf("count %0d, want %0d", got.count, want.count));
    endtask
  endclass

  pq_scoreboard sb = new();

  min_heap_priority_queue_top #(.CAPACITY(CAP)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) sb.check_response(rsp_o);
  end

  function automatic mhpq_pkg::in_t make_item(logic kind, logic [15:0] id,
                                              logic [15:0] pri);
    mhpq_pkg::in_t it;
    it.kind         = kind;
    it.task_id      = id;
    it.priority_req = pri;
    return it;
  endfunction

  task automatic send_item(input mhpq_pkg::in_t it);
    start <= 1'b1;
    req_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(it);
  endtask

  task automatic idle_maybe();
    if (!quiet && $urandom_range(99, 0) < 14) begin
      start <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int push_pct, int pri_max);
    logic kind;
    repeat (n) begin
      idle_maybe();
      kind = ($urandom_range(99, 0) < push_pct) ? mhpq_pkg::KIND_PUSH : mhpq_pkg::KIND_POP;
      send_item(make_item(kind, 16'($urandom_range(65535, 0)),
                          16'($urandom_range(pri_max, 0))));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    quiet  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(mhpq_pkg::KIND_POP,  16'hFFFF, 16'hFFFF));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'h0000, 16'h0000));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'hFFFF, 16'hFFFF));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'h1234, 16'h0007));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'h5678, 16'h0007));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'h9ABC, 16'h0007));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'hFFFF, 16'h0000));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'hA5A5, 16'h8000));
    repeat (7) send_item(make_item(mhpq_pkg::KIND_POP, 16'hFFFF, 16'hFFFF));
    send_item(make_item(mhpq_pkg::KIND_POP,  16'h0000, 16'h0000));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'h0000, 16'hFFFF));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'h8000, 16'h7FFF));
    send_item(make_item(mhpq_pkg::KIND_PUSH, 16'h0001, 16'hFFFF));
    repeat (3) send_item(make_item(mhpq_pkg::KIND_POP, 16'h5A5A, 16'h5A5A));
    wait_drained();

    run_random(300, 55, 65535);

    repeat (CAP + 6) begin
      idle_maybe();
      send_item(make_item(mhpq_pkg::KIND_PUSH, 16'($urandom_range(65535, 0)),
                          16'($urandom_range(15, 0))));
    end
    wait_drained();
    repeat (CAP + 4) begin
      idle_maybe();
      send_item(make_item(mhpq_pkg::KIND_POP, 16'($urandom_range(65535, 0)),
                          16'($urandom_range(65535, 0))));
    end

    quiet = 1'b1;
    run_random(150, 55, 3);
    quiet = 1'b0;
    run_random(150, 50, 3);
    wait_drained();

    run_random(250, 70, 65535);
    run_random(50, 20, 65535);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("min_heap_priority_queue_top_tb OK");
    end else begin
      $display("min_heap_priority_queue_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("min_heap_priority_queue_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mhpq_pkg.sv
rtl/mhpq_heap_ram.sv
rtl/mhpq_cmp.sv
rtl/mhpq_ctrl.sv
rtl/min_heap_priority_queue_top.sv
sim/min_heap_priority_queue_top_tb.sv
